FILE: rtl/bpfa_pkg.sv
// Package for the bitmap page frame allocator: constants, codes and word types.
`default_nettype none

package bpfa_pkg;

  // Fixed sizes of the command and result fields
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PADDR_W   = 28;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;

  // Page size and map word size
  localparam int unsigned PAGE_BYTES    = 4096;
  localparam int unsigned PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_PG_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);

  // Default page count and register reset values
  localparam int unsigned MAX_PAGES_DEFAULT = 65536;
  localparam logic [CNT_W-1:0] PAGE_LIMIT_RST = CNT_W'(65536);
  localparam logic [CNT_W-1:0] RESERVED_RST   = CNT_W'(514);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_LIMIT = 1'b0,
    REG_RESERVED   = 1'b1
  } reg_idx_e;

  // Command word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] phys_addr;
  } bpfa_in_t;

  // Result word
  typedef struct packed {
    status_e            status;
    logic [PADDR_W-1:0] page_addr;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   used_count;
  } bpfa_out_t;

endpackage

`default_nettype wire

FILE: rtl/bpfa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bpfa_ram #(
  parameter  int unsigned WIDTH = 64,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_frame_allocator.sv
// Top level of the bitmap first-fit page frame allocator.
//
// Command channel: a command word (command, phys_addr) is taken at a rising
// edge with start_i high and busy_o low. Every command gives one result word
// on res_o, shown for exactly one cycle with done_o high; the receiver cannot
// stall, so the word must be taken in that cycle. A new command may be
// started in the same cycle that a result is shown.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_wdata_i;
// ready is always high. Write it only while the block is idle.
// Steps from accept to done_o:
//   allocate: reads map words from word 0 up, one word per cycle through
//             the registered map RAM read port, and checks each in turn
//   free:     no map read when out of range, else read, then update
//   init:     one map word written per cycle, over all MAP_WORDS words
//   other:    answered from idle with no map access
// Commands are taken only while busy_o is low; the map RAM port and the
// single mask and priority-encode unit set the pace of an allocate.
// Reset: a clearing pass writes all MAP_WORDS map words to zero; busy_o
// is high until it ends, and no result is given for it. The used count and
// registers take their reset values.
`default_nettype none

module bitmap_page_frame_allocator #(
  parameter int unsigned MAX_PAGES = bpfa_pkg::MAX_PAGES_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire bpfa_pkg::bpfa_in_t                  cmd_i,
  output logic                                     done_o,
  output bpfa_pkg::bpfa_out_t                      res_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [bpfa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bpfa_pkg::CNT_W-1:0]          cfg_wdata_i
);

  localparam int unsigned WB      = bpfa_pkg::MAP_WORD_BITS;
  localparam int unsigned BIT_W   = bpfa_pkg::BIT_W;
  localparam int unsigned CNT_W   = bpfa_pkg::CNT_W;
  localparam int unsigned WORDS   = (MAX_PAGES + WB - 1) / WB;
  localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SPAN_W  = WORD_AW + BIT_W + 1;
  localparam int unsigned CMP_W   = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;
  localparam int unsigned LEFT_W  = BIT_W + 1;
  localparam int unsigned PA_W    = WORD_AW + BIT_W + bpfa_pkg::PAGE_SHIFT;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SCAN     = 4'b0010,
    ST_FREE_CHK = 4'b0100,
    ST_SWEEP    = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      page_limit_q, reserved_q;
  logic [CNT_W-1:0]      used_q, used_d;
  logic [CNT_W-1:0]      res_pages_q, res_pages_d;
  logic                  reply_q, reply_d;
  logic [WORD_AW-1:0]    sw_w_q, sw_w_d;
  logic [WORD_AW-1:0]    rd_w_q, rd_w_d;
  logic                  rd_done_q, rd_done_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [WORD_AW-1:0]    chk_w_q, chk_w_d;
  logic [WORD_AW-1:0]    fr_w_q, fr_w_d;
  logic [BIT_W-1:0]      fr_b_q, fr_b_d;
  logic                  done_q, done_d;
  bpfa_pkg::bpfa_out_t   out_q, out_d;

  logic [CNT_W-1:0]      lim;
  logic                  accept;
  logic [bpfa_pkg::ADDR_PG_W-1:0] in_page;
  logic                  in_range;

  logic                  ram_we, ram_re;
  logic [WORD_AW-1:0]    ram_waddr, ram_raddr;
  logic [WB-1:0]         ram_wdata, ram_rdata;

  logic [CMP_W-1:0]      m_base, m_lim, m_left;
  logic [LEFT_W-1:0]     m_cnt;
  logic [WB-1:0]         m_mask;
  logic [CMP_W-1:0]      chk_base, chk_next;
  logic [WB-1:0]         free_bits;
  logic                  hit;
  logic [BIT_W-1:0]      hit_b;
  logic [PA_W-1:0]       pa_full;

  // Effective page limit, clamped at the map size
  assign lim = (32'(page_limit_q) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_limit_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = out_q;

  // Free address to page number and range check
  assign in_page  = cmd_i.phys_addr[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
  assign in_range = (32'(in_page) < 32'(lim));

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_limit_q <= bpfa_pkg::PAGE_LIMIT_RST;
      reserved_q   <= bpfa_pkg::RESERVED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpfa_pkg::REG_PAGE_LIMIT: page_limit_q <= cfg_wdata_i;
        bpfa_pkg::REG_RESERVED:   reserved_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Shared mask unit: bits of the word at m_base that lie below m_lim
  always_comb begin
    chk_base = CMP_W'({chk_w_q, {BIT_W{1'b0}}});
    chk_next = chk_base + CMP_W'(WB);
    if (state_q == ST_SWEEP) begin
      m_base = CMP_W'({sw_w_q, {BIT_W{1'b0}}});
      m_lim  = CMP_W'(res_pages_q);
    end else begin
      m_base = chk_base;
      m_lim  = CMP_W'(lim);
    end
    m_left = (m_lim > m_base) ? (m_lim - m_base) : '0;
    m_cnt  = (m_left >= CMP_W'(WB)) ? LEFT_W'(WB) : m_left[LEFT_W-1:0];
    for (int j = 0; j < WB; j++) begin
      m_mask[j] = (LEFT_W'(j) < m_cnt);
    end
  end

  // Find the lowest free page in the checked word
  always_comb begin
    free_bits = ~ram_rdata & m_mask;
    hit       = |free_bits;
    hit_b     = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        hit_b = BIT_W'(j);
      end
    end
    pa_full = {chk_w_q, hit_b, {bpfa_pkg::PAGE_SHIFT{1'b0}}};
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    res_pages_d = res_pages_q;
    reply_d     = reply_q;
    sw_w_d      = sw_w_q;
    rd_w_d      = rd_w_q;
    rd_done_d   = rd_done_q;
    chk_vld_d   = chk_vld_q;
    chk_w_d     = chk_w_q;
    fr_w_d      = fr_w_q;
    fr_b_d      = fr_b_q;
    done_d      = 1'b0;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.status    = bpfa_pkg::ST_OK;
          out_d.page_addr = '0;
          unique case (cmd_i.command)
            bpfa_pkg::CMD_ALLOC: begin
              rd_w_d    = '0;
              rd_done_d = 1'b0;
              chk_vld_d = 1'b0;
              state_d   = ST_SCAN;
            end
            bpfa_pkg::CMD_FREE: begin
              fr_w_d = in_page[BIT_W +: WORD_AW];
              fr_b_d = in_page[BIT_W-1:0];
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = in_page[BIT_W +: WORD_AW];
                state_d   = ST_FREE_CHK;
              end else begin
                out_d.status = bpfa_pkg::ST_OUT_OF_RANGE;
                done_d       = 1'b1;
              end
            end
            bpfa_pkg::CMD_INIT: begin
              res_pages_d = (reserved_q > lim) ? lim : reserved_q;
              reply_d     = 1'b1;
              sw_w_d      = '0;
              state_d     = ST_SWEEP;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next map word read
        if (!rd_done_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_w_q;
          chk_w_d   = rd_w_q;
          chk_vld_d = 1'b1;
          rd_w_d    = rd_w_q + WORD_AW'(1);
          rd_done_d = (rd_w_q == LAST_WORD);
        end else begin
          chk_vld_d = 1'b0;
        end
        // Check the word read in the previous cycle
        if (chk_vld_q) begin
          if (hit) begin
            ram_we          = 1'b1;
            ram_waddr       = chk_w_q;
            ram_wdata       = ram_rdata | (WB'(1) << hit_b);
            used_d          = used_q + CNT_W'(1);
            out_d.page_addr = bpfa_pkg::PADDR_W'(pa_full);
            done_d          = 1'b1;
            state_d         = ST_IDLE;
          end else if (chk_w_q == LAST_WORD || chk_next >= CMP_W'(lim)) begin
            out_d.status = bpfa_pkg::ST_NO_FREE;
            done_d       = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end

      ST_FREE_CHK: begin
        if (ram_rdata[fr_b_q]) begin
          ram_we    = 1'b1;
          ram_waddr = fr_w_q;
          ram_wdata = ram_rdata & ~(WB'(1) << fr_b_q);
          if (used_q != '0) begin
            used_d = used_q - CNT_W'(1);
          end
        end else begin
          out_d.status = bpfa_pkg::ST_ALREADY_FREE;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SWEEP: begin
        // Write one map word per cycle: reserved pages set, the rest clear
        ram_we    = 1'b1;
        ram_waddr = sw_w_q;
        ram_wdata = m_mask;
        sw_w_d    = sw_w_q + WORD_AW'(1);
        if (sw_w_q == LAST_WORD) begin
          used_d  = res_pages_q;
          done_d  = reply_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_d.used_count = used_d;
    out_d.free_count = (lim > used_d) ? (lim - used_d) : '0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      used_q      <= '0;
      res_pages_q <= '0;
      reply_q     <= 1'b0;
      sw_w_q      <= '0;
      rd_w_q      <= '0;
      rd_done_q   <= 1'b0;
      chk_vld_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      res_pages_q <= res_pages_d;
      reply_q     <= reply_d;
      sw_w_q      <= sw_w_d;
      rd_w_q      <= rd_w_d;
      rd_done_q   <= rd_done_d;
      chk_vld_q   <= chk_vld_d;
      done_q      <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_w_q <= chk_w_d;
    fr_w_q  <= fr_w_d;
    fr_b_q  <= fr_b_d;
    out_q   <= out_d;
  end

  // Page frame map
  bpfa_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // No result word while the map is being swept
  a_no_done_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !done_q)
    else $error("result shown during map sweep");

  // An allocate or free update flips exactly one map bit
  a_one_bit_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != ST_SWEEP) |-> ($countones(ram_wdata ^ ram_rdata) == 1))
    else $error("map update does not flip exactly one bit");

  // An accepted command either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE || done_q))
    else $error("accepted command dropped");

  // Outside a sweep the used count moves by at most one page
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SWEEP) |=> (used_q == $past(used_q) ||
                               used_q == $past(used_q) + CNT_W'(1) ||
                               used_q == $past(used_q) - CNT_W'(1)))
    else $error("used count jumped");

endmodule

`default_nettype wire

FILE: bench/bitmap_page_frame_allocator_tb.sv
// Self-checking testbench for the bitmap first-fit page frame allocator.
module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;

  localparam int unsigned MAP_WORDS = MAX_PAGES_DEFAULT / MAP_WORD_BITS;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned DIR_ROWS = 35;
  localparam int unsigned PHASES = 14;
  localparam bpfa_out_t UNCHECKED = '{ST_OK, 28'h0, 17'd0, 17'd0};

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_e;

  // One step of the directed part: a command word or a register write
  typedef struct {
    row_kind_e kind;
    reg_idx_e idx;
    logic [CMD_W-1:0] cmd;
    logic [ADDR_W-1:0] arg;
    bit typed;
    bpfa_out_t want;
  } dir_row_t;

  // One random phase: register settings, length, and whether to reinit first
  typedef struct {
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] reserved;
    int unsigned items;
    bit reinit;
  } phase_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  bpfa_in_t cmd_i = '0;
  logic done_o;
  bpfa_out_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  // Shadow copy of the allocator state and registers
  logic [MAP_WORD_BITS-1:0] shadow_map [MAP_WORDS] = '{default: '0};
  int unsigned shadow_used = 0;
  int unsigned shadow_limit = PAGE_LIMIT_RST;
  int unsigned shadow_reserved = RESERVED_RST;

  bpfa_out_t pending_results [$];
  int unsigned owned_pages [$];
  int unsigned mismatch_count = 0;
  int unsigned item_count = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b1,
      '{ST_OK, 28'h0, 17'd65535, 17'd1}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0000_0FFF, 1'b1,
      '{ST_OK, 28'h0, 17'd65536, 17'd0}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0000_0000, 1'b1,
      '{ST_ALREADY_FREE, 28'h0, 17'd65536, 17'd0}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'hFFFF_FFFF, 1'b1,
      '{ST_OUT_OF_RANGE, 28'h0, 17'd65536, 17'd0}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0FFF_F000, 1'b1,
      '{ST_ALREADY_FREE, 28'h0, 17'd65536, 17'd0}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h1000_0000, 1'b1,
      '{ST_OUT_OF_RANGE, 28'h0, 17'd65536, 17'd0}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1,
      '{ST_OK, 28'h0, 17'd65536, 17'd0}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_INIT, 32'h0000_0000, 1'b1,
      '{ST_OK, 28'h0, 17'd65022, 17'd514}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b1,
      '{ST_OK, 28'h020_2000, 17'd65021, 17'd515}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'hFFFF_FFFF, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0020_2ABC, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h001F_F000, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CFG, REG_PAGE_LIMIT, CMD_ALLOC, 32'd2, 1'b0, UNCHECKED},
    '{ROW_CFG, REG_RESERVED, CMD_ALLOC, 32'h1_FFFF, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_INIT, 32'h0000_0000, 1'b1,
      '{ST_OK, 28'h0, 17'd0, 17'd2}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b1,
      '{ST_NO_FREE, 28'h0, 17'd0, 17'd2}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0000_1000, 1'b1,
      '{ST_OK, 28'h0, 17'd1, 17'd1}},
    '{ROW_CFG, REG_PAGE_LIMIT, CMD_ALLOC, 32'd0, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b1,
      '{ST_NO_FREE, 28'h0, 17'd0, 17'd1}},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0000_0000, 1'b1,
      '{ST_OUT_OF_RANGE, 28'h0, 17'd0, 17'd1}},
    '{ROW_CFG, REG_PAGE_LIMIT, CMD_ALLOC, 32'h1_FFFF, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CFG, REG_RESERVED, CMD_ALLOC, 32'd0, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_INIT, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CFG, REG_PAGE_LIMIT, CMD_ALLOC, 32'd64, 1'b0, UNCHECKED},
    '{ROW_CFG, REG_RESERVED, CMD_ALLOC, 32'd63, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_INIT, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b0, UNCHECKED},
    '{ROW_CFG, REG_PAGE_LIMIT, CMD_ALLOC, 32'd1, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_FREE, 32'h0003_F000, 1'b0, UNCHECKED},
    '{ROW_CMD, REG_PAGE_LIMIT, CMD_ALLOC, 32'h0000_0000, 1'b0, UNCHECKED}
  };

  phase_t phase_table [PHASES] = '{
    '{17'd64, 17'd0, 120, 1'b1},
    '{17'd65, 17'd1, 120, 1'b1},
    '{17'd130, 17'd3, 150, 1'b1},
    // lower the limit under the pages in use, keep the map
    '{17'd40, 17'd3, 80, 1'b0},
    '{17'd200, 17'h1_FFFF, 100, 1'b1},
    '{17'd65536, 17'd514, 150, 1'b1},
    '{17'd127, 17'd126, 100, 1'b1},
    '{17'd300, 17'd20, 150, 1'b1},
    '{17'd1, 17'd0, 40, 1'b1},
    '{17'd0, 17'd5, 30, 1'b1},
    '{17'h1_FFFF, 17'd65536, 12, 1'b1},
    '{17'd100, 17'd40, 150, 1'b1},
    '{17'd96, 17'd0, 150, 1'b1},
    '{17'd65536, 17'd0, 180, 1'b0}
  };

  bitmap_page_frame_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("bitmap_page_frame_allocator: mismatch");
    $finish;
  end

  function automatic int unsigned eff_limit();
    return (shadow_limit > MAX_PAGES_DEFAULT) ? MAX_PAGES_DEFAULT : shadow_limit;
  endfunction

  // Bits of map word w that stand for pages below n
  function automatic logic [MAP_WORD_BITS-1:0] word_mask(int unsigned w, int unsigned n);
    int unsigned base = w * MAP_WORD_BITS;
    if (n <= base) return '0;
    if (n - base >= MAP_WORD_BITS) return '1;
    return (64'd1 << (n - base)) - 64'd1;
  endfunction

  // Apply one command word to the shadow state and form its result word
  task automatic allocator_step(input bpfa_in_t w, output bpfa_out_t r);
    int unsigned lim;
    int unsigned page;
    int unsigned keep;
    logic [MAP_WORD_BITS-1:0] avail;
    bit found;
    lim = eff_limit();
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (w.command)
      CMD_ALLOC: begin
        for (int unsigned wi = 0; wi < MAP_WORDS && !found; wi++) begin
          avail = ~shadow_map[wi] & word_mask(wi, lim);
          if (avail != '0) begin
            for (int unsigned b = 0; b < MAP_WORD_BITS && !found; b++) begin
              if (avail[b]) begin
                shadow_map[wi][b] = 1'b1;
                shadow_used++;
                r.page_addr = PADDR_W'((wi * MAP_WORD_BITS + b) * PAGE_BYTES);
                found = 1'b1;
              end
            end
          end
        end
        if (!found) r.status = ST_NO_FREE;
      end
      CMD_FREE: begin
        page = w.phys_addr >> PAGE_SHIFT;
        if (page >= lim) begin
          r.status = ST_OUT_OF_RANGE;
        end else if (!shadow_map[page / MAP_WORD_BITS][page % MAP_WORD_BITS]) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          shadow_map[page / MAP_WORD_BITS][page % MAP_WORD_BITS] = 1'b0;
          if (shadow_used > 0) shadow_used--;
        end
      end
      CMD_INIT: begin
        // reserved count is clamped at the limit
        keep = (shadow_reserved > lim) ? lim : shadow_reserved;
        for (int unsigned wi = 0; wi < MAP_WORDS; wi++) shadow_map[wi] = word_mask(wi, keep);
        shadow_used = keep;
      end
      default: begin
      end
    endcase
    r.free_count = CNT_W'((lim > shadow_used) ? lim - shadow_used : 0);
    r.used_count = CNT_W'(shadow_used);
  endtask

  // Hold both channels quiet until every expected word is back and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy_o || !rst_ni);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CNT_W-1:0] val);
    drain();
    start_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_PAGE_LIMIT) shadow_limit = val;
    else shadow_reserved = val;
  endtask

  // Predict, queue the expected word, and drive the command until it is taken
  task automatic run_word(input bpfa_in_t w, input bit typed, input bpfa_out_t want);
    bpfa_out_t r;
    allocator_step(w, r);
    pending_results.push_back(typed ? want : r);
    if (w.command == CMD_ALLOC && r.status == ST_OK) owned_pages.push_back(r.page_addr >> PAGE_SHIFT);
    if (w.command == CMD_INIT) owned_pages.delete();
    cfg_valid_i <= 1'b0;
    start_i <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy_o || !rst_ni);
  endtask

  // Mostly allocate and free of owned pages; some stray frees, inits and unknown commands
  task automatic next_random_word(output bpfa_in_t w);
    int unsigned lim;
    int unsigned roll;
    int unsigned k;
    int unsigned page;
    int unsigned alloc_share;
    lim = eff_limit();
    alloc_share = (shadow_used >= lim) ? 8 : 50;
    roll = $urandom_range(0, 99);
    w.phys_addr = $urandom;
    if (roll < 3) begin
      w.command = CMD_UNKNOWN;
    end else if (roll < 6) begin
      w.command = CMD_INIT;
    end else if (roll < 6 + alloc_share) begin
      w.command = CMD_ALLOC;
    end else begin
      w.command = CMD_FREE;
      roll = $urandom_range(0, 99);
      if (roll < 70 && owned_pages.size() != 0) begin
        k = $urandom_range(0, owned_pages.size() - 1);
        page = owned_pages[k];
        owned_pages.delete(k);
        w.phys_addr = {page[ADDR_PG_W-1:0], w.phys_addr[PAGE_SHIFT-1:0]};
      end else if (roll < 85) begin
        page = $urandom_range(0, (lim < 1024) ? lim + 1 : 1024);
        w.phys_addr = {page[ADDR_PG_W-1:0], w.phys_addr[PAGE_SHIFT-1:0]};
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin : check_results
    bpfa_out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with none pending, used_count", 32'd0,
                      32'(res_o.used_count));
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(res_o.status));
        if (res_o.page_addr !== want.page_addr)
          flag_mismatch("page_addr", 32'(want.page_addr), 32'(res_o.page_addr));
        if (res_o.free_count !== want.free_count)
          flag_mismatch("free_count", 32'(want.free_count), 32'(res_o.free_count));
        if (res_o.used_count !== want.used_count)
          flag_mismatch("used_count", 32'(want.used_count), 32'(res_o.used_count));
      end
    end
  end

  initial begin : stimulus
    bpfa_in_t w;
    int unsigned idle_pct;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        write_reg(dir_table[i].idx, dir_table[i].arg[CNT_W-1:0]);
      end else begin
        w.command = dir_table[i].cmd;
        w.phys_addr = dir_table[i].arg;
        run_word(w, dir_table[i].typed, dir_table[i].want);
      end
    end

    // Random phases, each under its own register settings
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_reg(REG_PAGE_LIMIT, phase_table[p].limit);
      write_reg(REG_RESERVED, phase_table[p].reserved);
      if (phase_table[p].reinit) begin
        w.command = CMD_INIT;
        w.phys_addr = $urandom;
        run_word(w, 1'b0, UNCHECKED);
      end
      for (int unsigned n = 0; n < phase_table[p].items; n++) begin
        idle_pct = (item_count < 510) ? 7 : (item_count < 1020) ? 51 : 0;
        if ($urandom_range(0, 99) < idle_pct) begin
          start_i <= 1'b0;
          cfg_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end else if ($urandom_range(0, 99) == 0) begin
          drain();
        end
        next_random_word(w);
        run_word(w, 1'b0, UNCHECKED);
        item_count++;
      end
    end

    // Let the last words come back, then settle
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("bitmap_page_frame_allocator: match");
    end else begin
      $display("bitmap_page_frame_allocator: mismatch");
    end
    $finish;
  end

endmodule
